### design/ctrc_pkg.sv
package ctrc_pkg;

  // Field widths of the compact target format.
  localparam int unsigned WordW  = 32;
  localparam int unsigned MantW  = 23;
  localparam int unsigned SizeW  = 8;
  localparam int unsigned SpanW  = 7;

  // Block spacing and the clamp window, in seconds.
  localparam int signed Spacing = 60;
  localparam int signed SpanMin = Spacing * 3 / 4;
  localparam int signed SpanMax = Spacing * 3 / 2;

  localparam logic [WordW-1:0] MantMask = 32'h007f_ffff;

  // Reciprocal of 15 for a 32-bit dividend: q = (z * Recip15) >> Recip15Sh.
  localparam logic [WordW-1:0] Recip15   = 32'h8888_8889;
  localparam int unsigned      Recip15Sh = 35;

  // Register reset values.
  localparam logic [WordW-1:0] ForkHeightRst = 32'd145000;
  localparam logic [WordW-1:0] MaxTargetRst  = 32'h1e0f_fff0;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_FORK_HEIGHT = 1'b0,
    REG_MAX_TARGET  = 1'b1
  } reg_idx_e;

  // Input item.
  typedef struct packed {
    logic [WordW-1:0] block_height;
    logic             link_ok;
    logic [WordW-1:0] prev_target;
    logic [WordW-1:0] prev_time;
    logic             grandparent_present;
    logic [WordW-1:0] grandparent_time;
    logic [WordW-1:0] block_target;
  } in_t;

  // Result item.
  typedef struct packed {
    logic [WordW-1:0] expected_target;
    logic             retarget_checked;
    logic             header_ok;
  } out_t;

  // Fields carried unchanged down the pipeline for the final check.
  typedef struct packed {
    logic             checked;
    logic             gp_present;
    logic             link_ok;
    logic [WordW-1:0] claimed;
  } side_t;

  // After the timespan stage.
  typedef struct packed {
    logic [MantW-1:0] mant;
    logic [SizeW-1:0] size;
    logic [SpanW-1:0] span;
    side_t            side;
  } span_t;

  // After the mantissa scaling stage: four times mantissa times timespan.
  typedef struct packed {
    logic [WordW-1:0] p4;
    logic [SizeW-1:0] size;
    side_t            side;
  } prod_t;

  // After the reciprocal stage: quotient of p4 by fifteen.
  typedef struct packed {
    logic [WordW-1:0]   p4;
    logic [WordW-5:0]   q;
    logic [SizeW-1:0]   size;
    side_t              side;
  } quot_t;

  // After normalisation: size may reach 256, which always exceeds the cap.
  typedef struct packed {
    logic [SizeW:0]   size;
    logic [MantW-1:0] mant;
    side_t            side;
  } norm_t;

endpackage

### design/ctrc_span.sv
module ctrc_span (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  ctrc_pkg::in_t                 data_i,
  input  logic [ctrc_pkg::WordW-1:0]    fork_height_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output ctrc_pkg::span_t               data_o
);
  import ctrc_pkg::*;

  logic signed [WordW:0]   raw;
  logic signed [WordW+1:0] diff;
  logic signed [WordW+1:0] filt;
  logic signed [WordW+2:0] span;
  logic [SpanW-1:0]        span_clamp;
  logic                    valid_q;
  span_t                   data_d;
  span_t                   data_q;

  // Raw timespan between the previous block and its parent.
  always_comb begin
    if (data_i.grandparent_present) begin
      raw = $signed({1'b0, data_i.prev_time}) - $signed({1'b0, data_i.grandparent_time});
    end else begin
      raw = '0;
    end
  end

  // Low-pass filter by one eighth, the division truncating toward zero.
  assign diff = (WordW+2)'(Spacing) - (WordW+2)'(raw);
  always_comb begin
    if (diff < 0) begin
      filt = (diff + (WordW+2)'(7)) >>> 3;
    end else begin
      filt = diff >>> 3;
    end
  end
  assign span = (WordW+3)'(Spacing) - (WordW+3)'(filt);

  // Clamp the filtered timespan to the allowed window.
  always_comb begin
    priority if (span < (WordW+3)'(SpanMin)) begin
      span_clamp = SpanW'(SpanMin);
    end else if (span > (WordW+3)'(SpanMax)) begin
      span_clamp = SpanW'(SpanMax);
    end else begin
      span_clamp = span[SpanW-1:0];
    end
  end

  always_comb begin
    data_d.mant            = data_i.prev_target[MantW-1:0];
    data_d.size            = data_i.prev_target[WordW-1 -: SizeW];
    data_d.span            = span_clamp;
    data_d.side.checked    = (data_i.block_height >= fork_height_i);
    data_d.side.gp_present = data_i.grandparent_present;
    data_d.side.link_ok    = data_i.link_ok;
    data_d.side.claimed    = data_i.block_target;
  end

  assign ready_o = !valid_q || ready_i;

  // Stage register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### design/ctrc_scale.sv
module ctrc_scale (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  ctrc_pkg::span_t   data_i,
  output logic              valid_o,
  input  logic              ready_i,
  output ctrc_pkg::quot_t   data_o
);
  import ctrc_pkg::*;

  logic [MantW+SpanW-1:0] mul_span;
  logic [2*WordW-1:0]     mul_recip;
  logic                   p_valid_q;
  logic                   p_ready;
  prod_t                  p_d;
  prod_t                  p_q;
  logic                   q_valid_q;
  quot_t                  q_d;
  quot_t                  q_q;

  // First stage: mantissa times timespan, times four.
  assign mul_span = MantW'(data_i.mant) * (MantW+SpanW)'(data_i.span);
  always_comb begin
    p_d.p4   = {mul_span, 2'b00};
    p_d.size = data_i.size;
    p_d.side = data_i.side;
  end

  assign p_ready = !q_valid_q || ready_i;
  assign ready_o = !p_valid_q || p_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
    end else if (ready_o) begin
      p_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      p_q <= p_d;
    end
  end

  // Second stage: divide four times the product by fifteen by reciprocal.
  assign mul_recip = {{WordW{1'b0}}, p_q.p4} * {{WordW{1'b0}}, Recip15};
  always_comb begin
    q_d.p4   = p_q.p4;
    q_d.q    = mul_recip[Recip15Sh +: (WordW-4)];
    q_d.size = p_q.size;
    q_d.side = p_q.side;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_valid_q <= 1'b0;
    end else if (p_ready) begin
      q_valid_q <= p_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_ready && p_valid_q) begin
      q_q <= q_d;
    end
  end

  assign valid_o = q_valid_q;
  assign data_o  = q_q;

endmodule

### design/ctrc_norm.sv
module ctrc_norm (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  ctrc_pkg::quot_t               data_i,
  input  logic [ctrc_pkg::WordW-1:0]    max_target_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output ctrc_pkg::out_t                data_o
);
  import ctrc_pkg::*;

  logic [WordW-1:0]        scaled;
  logic signed [SizeW+1:0] size_m1;
  logic [1:0]              n_mant;
  logic [1:0]              n_size;
  logic [1:0]              n_shift;
  logic [WordW-1:0]        shifted;
  logic                    n_valid_q;
  logic                    n_ready;
  norm_t                   n_d;
  norm_t                   n_q;
  logic [WordW-1:0]        value;
  logic                    over;
  logic [WordW-1:0]        target;
  logic                    o_valid_q;
  out_t                    o_d;
  out_t                    o_q;

  // Mantissa times 64/15 is 4p plus 4p/15; the size byte drops by one.
  assign scaled  = data_i.p4 + WordW'(data_i.q);
  assign size_m1 = $signed({2'b00, data_i.size}) - (SizeW+2)'(1);

  // Byte shifts needed for the mantissa to fit and for the size to reach one.
  always_comb begin
    priority if ((scaled >> 8) > MantMask) begin
      n_mant = 2'd2;
    end else if (scaled > MantMask) begin
      n_mant = 2'd1;
    end else begin
      n_mant = 2'd0;
    end
  end

  always_comb begin
    priority if (size_m1 < 0) begin
      n_size = 2'd2;
    end else if (size_m1 == 0) begin
      n_size = 2'd1;
    end else begin
      n_size = 2'd0;
    end
  end

  assign n_shift = (n_mant > n_size) ? n_mant : n_size;
  assign shifted = scaled >> {n_shift, 3'b000};

  always_comb begin
    n_d.size = (SizeW+1)'(size_m1 + $signed({{SizeW{1'b0}}, n_shift}));
    n_d.mant = shifted[MantW-1:0];
    n_d.side = data_i.side;
  end

  assign n_ready = !o_valid_q || ready_i;
  assign ready_o = !n_valid_q || n_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_valid_q <= 1'b0;
    end else if (ready_o) begin
      n_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      n_q <= n_d;
    end
  end

  // Cap at the maximum target and compare with the claimed target.
  assign value  = {n_q.size[SizeW-1:0], 1'b0, n_q.mant};
  assign over   = n_q.size[SizeW] || (value > max_target_i);
  assign target = over ? max_target_i : value;

  always_comb begin
    o_d.expected_target  = n_q.side.checked ? target : '0;
    o_d.retarget_checked = n_q.side.checked;
    o_d.header_ok        = n_q.side.link_ok &&
                           !(n_q.side.checked && n_q.side.gp_present &&
                             (n_q.side.claimed != target));
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (n_ready) begin
      o_valid_q <= n_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (n_ready && n_valid_q) begin
      o_q <= o_d;
    end
  end

  assign valid_o = o_valid_q;
  assign data_o  = o_q;

endmodule

### design/compact_target_retarget_check.sv
// The pipeline has five register stages and takes one item per cycle while the output
// is not stalled.
// The stages are timespan filter, mantissa multiply, reciprocal multiply by 1/15,
// byte normalisation, and cap/compare; a stalled output holds items back, losing none.
// Reset (rst_ni low, asynchronous) empties every stage and restores fork_height
// to 145000 and max_target to 0x1e0ffff0.
module compact_target_retarget_check (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  ctrc_pkg::reg_idx_e            cfg_idx_i,
  input  logic [ctrc_pkg::WordW-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  ctrc_pkg::in_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output ctrc_pkg::out_t                out_data_o
);
  import ctrc_pkg::*;

  logic [WordW-1:0] fork_height_q;
  logic [WordW-1:0] max_target_q;
  logic             in_ready;
  logic             s_valid;
  logic             s_ready;
  span_t            s_data;
  logic             c_valid;
  logic             c_ready;
  quot_t            c_data;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fork_height_q <= ForkHeightRst;
      max_target_q  <= MaxTargetRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FORK_HEIGHT: fork_height_q <= cfg_wdata_i;
        REG_MAX_TARGET:  max_target_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  ctrc_span u_span (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (in_valid_i),
    .ready_o       (in_ready),
    .data_i        (in_data_i),
    .fork_height_i (fork_height_q),
    .valid_o       (s_valid),
    .ready_i       (s_ready),
    .data_o        (s_data)
  );

  ctrc_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_valid),
    .ready_o (s_ready),
    .data_i  (s_data),
    .valid_o (c_valid),
    .ready_i (c_ready),
    .data_o  (c_data)
  );

  ctrc_norm u_norm (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (c_valid),
    .ready_o      (c_ready),
    .data_i       (c_data),
    .max_target_i (max_target_q),
    .valid_o      (out_valid_o),
    .ready_i      (!out_stall_i),
    .data_o       (out_data_o)
  );

  assign in_stall_o = !in_ready;

  // Below the fork height no target is reported.
  a_zero_below_fork: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.retarget_checked |-> out_data_o.expected_target == '0)
    else $error("expected target not zero below fork height");

  // A computed target never exceeds the ceiling.
  a_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.retarget_checked |->
      out_data_o.expected_target <= max_target_q)
    else $error("expected target above maximum target");

  // The input side stalls only when every stage is full and the output is held.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i && c_valid && s_valid)
    else $error("input stalled with room in the pipeline");

  // An item that enters an empty pipeline appears at the output if the output is not stalled meanwhile.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !s_valid && !c_valid && !out_valid_o && !out_stall_i
      ##1 !out_stall_i ##1 !out_stall_i ##1 !out_stall_i ##1 !out_stall_i |=>
      out_valid_o)
    else $error("item lost in the pipeline");

endmodule
